// ===== src/bqdc_pkg.sv =====
// Shared types, constants, microcode and arithmetic helpers of the DC-removing biquad.
package bqdc_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 30;
    localparam int COEF_BITS      = 32;
    localparam int STATE_BITS     = 48;
    localparam int STATE_FRAC     = 40;
    localparam int CFG_DATA_BITS  = COEF_BITS;
    localparam int CFG_IDX_BITS   = 3;

    localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
    localparam int PROD_SHIFT = SAMPLE_BITS - 1 + COEF_FRAC_BITS - STATE_FRAC;
    localparam int PROD_RSH   = (PROD_SHIFT > 0) ? PROD_SHIFT : 0;
    localparam int PROD_LSH   = (PROD_SHIFT < 0) ? -PROD_SHIFT : 0;
    localparam int OUT_SHIFT  = STATE_FRAC - (SAMPLE_BITS - 1);

    localparam int TERM_BITS  = PROD_BITS + PROD_LSH;
    localparam int WIDE_A     = (PROD_BITS + 1 > TERM_BITS) ? PROD_BITS + 1 : TERM_BITS;
    localparam int ACC_BITS   = ((WIDE_A > STATE_BITS) ? WIDE_A : STATE_BITS) + 2;

    localparam logic signed [ACC_BITS-1:0] PROD_HALF = (ACC_BITS'(1) << PROD_RSH) >> 1;
    localparam logic signed [ACC_BITS-1:0] OUT_HALF  = ACC_BITS'(1) << (OUT_SHIFT - 1);

    localparam logic [COEF_BITS-1:0] GAIN_B0_RESET = COEF_BITS'(1) << COEF_FRAC_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_B0      = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_B1      = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_B2      = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_A1  = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_A2  = CFG_IDX_BITS'(4);
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_LEVEL = CFG_IDX_BITS'(5);

    localparam int NUM_STEPS = 11;
    localparam int PC_BITS   = $clog2(NUM_STEPS);

    localparam logic [PC_BITS-1:0] ST_INPUT   = PC_BITS'(0);
    localparam logic [PC_BITS-1:0] ST_MUL_B0  = PC_BITS'(1);
    localparam logic [PC_BITS-1:0] ST_MUL_B1  = PC_BITS'(2);
    localparam logic [PC_BITS-1:0] ST_ACC_Y   = PC_BITS'(3);
    localparam logic [PC_BITS-1:0] ST_OUT_Y   = PC_BITS'(4);
    localparam logic [PC_BITS-1:0] ST_MUL_A1  = PC_BITS'(5);
    localparam logic [PC_BITS-1:0] ST_MUL_B2  = PC_BITS'(6);
    localparam logic [PC_BITS-1:0] ST_SUB_A1  = PC_BITS'(7);
    localparam logic [PC_BITS-1:0] ST_NEXT_D1 = PC_BITS'(8);
    localparam logic [PC_BITS-1:0] ST_SUB_A2  = PC_BITS'(9);
    localparam logic [PC_BITS-1:0] ST_NEXT_D2 = PC_BITS'(10);
    localparam logic [PC_BITS-1:0] LAST_STEP  = PC_BITS'(NUM_STEPS - 1);

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_OUT_FREE
    } cond_t;

    typedef enum logic [2:0] {
        COEF_B0,
        COEF_B1,
        COEF_B2,
        COEF_A1,
        COEF_A2
    } coef_sel_t;

    typedef enum logic {
        OPND_X,
        OPND_Y
    } opnd_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_D1,
        ACC_LOAD_D2,
        ACC_LOAD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic      x_load;
        logic      mul_en;
        coef_sel_t coef;
        opnd_sel_t opnd;
        acc_op_t   acc_op;
        logic      y_load;
        logic      d1_load;
        logic      d2_load;
        logic      clr_on_last;
        logic      out_load;
    } ctrl_t;

    typedef struct packed {
        cond_t              cond;
        logic               jump;
        logic [PC_BITS-1:0] target;
        ctrl_t              ctl;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
        ucode_t w;
        w = '0;
        w.cond = COND_ALWAYS;
        w.ctl.acc_op = ACC_HOLD;
        w.target = ST_INPUT;
        case (pc)
            ST_INPUT:
            begin
                w.cond = COND_IN_VALID;
                w.ctl.x_load = 1'b1;
            end
            ST_MUL_B0:
            begin
                w.ctl.mul_en = 1'b1;
                w.ctl.coef = COEF_B0;
                w.ctl.opnd = OPND_X;
            end
            ST_MUL_B1:
            begin
                w.ctl.mul_en = 1'b1;
                w.ctl.coef = COEF_B1;
                w.ctl.opnd = OPND_X;
            end
            ST_ACC_Y:
            begin
                w.ctl.acc_op = ACC_LOAD_D1;
            end
            ST_OUT_Y:
            begin
                w.ctl.y_load = 1'b1;
                w.ctl.acc_op = ACC_LOAD_D2;
            end
            ST_MUL_A1:
            begin
                w.ctl.mul_en = 1'b1;
                w.ctl.coef = COEF_A1;
                w.ctl.opnd = OPND_Y;
            end
            ST_MUL_B2:
            begin
                w.ctl.mul_en = 1'b1;
                w.ctl.coef = COEF_B2;
                w.ctl.opnd = OPND_X;
            end
            ST_SUB_A1:
            begin
                w.ctl.acc_op = ACC_SUB;
                w.ctl.mul_en = 1'b1;
                w.ctl.coef = COEF_A2;
                w.ctl.opnd = OPND_Y;
            end
            ST_NEXT_D1:
            begin
                w.ctl.d1_load = 1'b1;
                w.ctl.acc_op = ACC_LOAD;
            end
            ST_SUB_A2:
            begin
                w.ctl.acc_op = ACC_SUB;
            end
            ST_NEXT_D2:
            begin
                w.cond = COND_OUT_FREE;
                w.ctl.d2_load = 1'b1;
                w.ctl.clr_on_last = 1'b1;
                w.ctl.out_load = 1'b1;
                w.jump = 1'b1;
                w.target = ST_INPUT;
            end
            default:
            begin
                w.jump = 1'b1;
                w.target = ST_INPUT;
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_BITS-1:0] v
    );
        logic [ACC_BITS-SAMPLE_BITS:0] top;
        top = v[ACC_BITS-1:SAMPLE_BITS-1];
        if (top == '0 || top == '1)
            return v[SAMPLE_BITS-1:0];
        else if (v[ACC_BITS-1])
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [ACC_BITS-1:0] v
    );
        logic [ACC_BITS-STATE_BITS:0] top;
        top = v[ACC_BITS-1:STATE_BITS-1];
        if (top == '0 || top == '1)
            return v[STATE_BITS-1:0];
        else if (v[ACC_BITS-1])
            return {1'b1, {(STATE_BITS-1){1'b0}}};
        else
            return {1'b0, {(STATE_BITS-1){1'b1}}};
    endfunction

    // Product to state format: round to nearest, ties toward positive infinity.
    function automatic logic signed [ACC_BITS-1:0] scale_prod(
        input logic signed [PROD_BITS-1:0] p
    );
        logic signed [ACC_BITS-1:0] w;
        w = ACC_BITS'(p);
        w = w + PROD_HALF;
        w = w >>> PROD_RSH;
        return w <<< PROD_LSH;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] round_out(
        input logic signed [ACC_BITS-1:0] v
    );
        logic signed [ACC_BITS-1:0] w;
        w = v + OUT_HALF;
        w = w >>> OUT_SHIFT;
        return sat_sample(w);
    endfunction

endpackage

// ===== src/bqdc_seq.sv =====
// Microcode sequencer: step counter, control store and condition logic.
module bqdc_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             out_free,
    output logic             in_ready,
    output bqdc_pkg::ctrl_t  ctrl
);

    logic [bqdc_pkg::PC_BITS-1:0] pc_reg;
    logic [bqdc_pkg::PC_BITS-1:0] pc_next;
    bqdc_pkg::ucode_t             word;
    logic                         fire;

    assign word = bqdc_pkg::ucode_rom(pc_reg);
    assign in_ready = (word.cond == bqdc_pkg::COND_IN_VALID);

    always_comb
    begin
        unique case (word.cond)
            bqdc_pkg::COND_ALWAYS:   fire = 1'b1;
            bqdc_pkg::COND_IN_VALID: fire = in_valid;
            bqdc_pkg::COND_OUT_FREE: fire = out_free;
            default:                 fire = 1'b0;
        endcase
    end

    always_comb
    begin
        ctrl = word.ctl;
        ctrl.x_load = word.ctl.x_load & fire;
        ctrl.mul_en = word.ctl.mul_en & fire;
        ctrl.y_load = word.ctl.y_load & fire;
        ctrl.d1_load = word.ctl.d1_load & fire;
        ctrl.d2_load = word.ctl.d2_load & fire;
        ctrl.clr_on_last = word.ctl.clr_on_last & fire;
        ctrl.out_load = word.ctl.out_load & fire;
        if (!fire)
            ctrl.acc_op = bqdc_pkg::ACC_HOLD;
    end

    always_comb
    begin
        if (!fire)
            pc_next = pc_reg;
        else if (word.jump)
            pc_next = word.target;
        else
            pc_next = pc_reg + bqdc_pkg::PC_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= bqdc_pkg::ST_INPUT;
        else
            pc_reg <= pc_next;
    end

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= bqdc_pkg::LAST_STEP)
        else $error("step counter left the program");

    a_in_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> pc_reg == bqdc_pkg::ST_MUL_B0)
        else $error("input transfer did not start the program");

    a_out_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |=> pc_reg == bqdc_pkg::ST_INPUT)
        else $error("result load did not return to the input step");

endmodule

// ===== src/bqdc_dp.sv =====
// Datapath: configuration registers, shared multiplier, accumulator, delay state and output register.
module bqdc_dp (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  bqdc_pkg::ctrl_t                          ctrl,
    input  logic signed [bqdc_pkg::SAMPLE_BITS-1:0]  sample_in,
    input  logic                                     block_end,
    input  logic                                     cfg_we,
    input  logic [bqdc_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [bqdc_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  logic                                     out_ready,
    output logic                                     out_free,
    output logic                                     out_valid,
    output logic signed [bqdc_pkg::SAMPLE_BITS-1:0]  sample_out,
    output logic                                     out_last
);

    logic signed [bqdc_pkg::COEF_BITS-1:0]   b0_reg;
    logic signed [bqdc_pkg::COEF_BITS-1:0]   b1_reg;
    logic signed [bqdc_pkg::COEF_BITS-1:0]   b2_reg;
    logic signed [bqdc_pkg::COEF_BITS-1:0]   a1_reg;
    logic signed [bqdc_pkg::COEF_BITS-1:0]   a2_reg;
    logic signed [bqdc_pkg::SAMPLE_BITS-1:0] offset_reg;

    logic signed [bqdc_pkg::SAMPLE_BITS-1:0] x_reg;
    logic signed [bqdc_pkg::SAMPLE_BITS-1:0] y_reg;
    logic                                    last_reg;
    logic signed [bqdc_pkg::PROD_BITS-1:0]   p_reg;
    logic signed [bqdc_pkg::ACC_BITS-1:0]    t_reg;
    logic signed [bqdc_pkg::ACC_BITS-1:0]    acc_reg;
    logic signed [bqdc_pkg::ACC_BITS-1:0]    acc_next;
    logic signed [bqdc_pkg::STATE_BITS-1:0]  d1_reg;
    logic signed [bqdc_pkg::STATE_BITS-1:0]  d2_reg;
    logic                                    out_valid_reg;
    logic signed [bqdc_pkg::SAMPLE_BITS-1:0] sample_out_reg;
    logic                                    out_last_reg;

    logic signed [bqdc_pkg::ACC_BITS-1:0]    diff;
    logic signed [bqdc_pkg::COEF_BITS-1:0]   coef_mux;
    logic signed [bqdc_pkg::SAMPLE_BITS-1:0] opnd_mux;
    logic signed [bqdc_pkg::PROD_BITS-1:0]   prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= bqdc_pkg::GAIN_B0_RESET;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bqdc_pkg::REG_GAIN_B0:      b0_reg <= cfg_data;
                bqdc_pkg::REG_GAIN_B1:      b1_reg <= cfg_data;
                bqdc_pkg::REG_GAIN_B2:      b2_reg <= cfg_data;
                bqdc_pkg::REG_FEEDBACK_A1:  a1_reg <= cfg_data;
                bqdc_pkg::REG_FEEDBACK_A2:  a2_reg <= cfg_data;
                bqdc_pkg::REG_OFFSET_LEVEL: offset_reg <= cfg_data[bqdc_pkg::SAMPLE_BITS-1:0];
                default:                    ;
            endcase
        end
    end

    assign diff = bqdc_pkg::ACC_BITS'(sample_in) - bqdc_pkg::ACC_BITS'(offset_reg);

    always_comb
    begin
        unique case (ctrl.coef)
            bqdc_pkg::COEF_B0: coef_mux = b0_reg;
            bqdc_pkg::COEF_B1: coef_mux = b1_reg;
            bqdc_pkg::COEF_B2: coef_mux = b2_reg;
            bqdc_pkg::COEF_A1: coef_mux = a1_reg;
            bqdc_pkg::COEF_A2: coef_mux = a2_reg;
            default:           coef_mux = '0;
        endcase
    end

    assign opnd_mux = (ctrl.opnd == bqdc_pkg::OPND_Y) ? y_reg : x_reg;
    assign prod = coef_mux * opnd_mux;

    always_comb
    begin
        unique case (ctrl.acc_op)
            bqdc_pkg::ACC_HOLD:    acc_next = acc_reg;
            bqdc_pkg::ACC_LOAD_D1: acc_next = bqdc_pkg::ACC_BITS'(d1_reg) + t_reg;
            bqdc_pkg::ACC_LOAD_D2: acc_next = bqdc_pkg::ACC_BITS'(d2_reg) + t_reg;
            bqdc_pkg::ACC_LOAD:    acc_next = t_reg;
            bqdc_pkg::ACC_SUB:     acc_next = acc_reg - t_reg;
            default:               acc_next = acc_reg;
        endcase
    end

    // The scaled product is registered from the product register in the following cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.x_load)
        begin
            x_reg <= bqdc_pkg::sat_sample(diff);
            last_reg <= block_end;
        end
        if (ctrl.mul_en)
            p_reg <= prod;
        t_reg <= bqdc_pkg::scale_prod(p_reg);
        acc_reg <= acc_next;
        if (ctrl.y_load)
            y_reg <= bqdc_pkg::round_out(acc_reg);
        if (ctrl.out_load)
        begin
            sample_out_reg <= y_reg;
            out_last_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg <= '0;
            d2_reg <= '0;
        end
        else
        begin
            if (ctrl.clr_on_last && last_reg)
            begin
                d1_reg <= '0;
                d2_reg <= '0;
            end
            else
            begin
                if (ctrl.d1_load)
                    d1_reg <= bqdc_pkg::sat_state(acc_reg);
                if (ctrl.d2_load)
                    d2_reg <= bqdc_pkg::sat_state(acc_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign out_last = out_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register loaded while still holding a result");

    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load && last_reg |=> d1_reg == '0 && d2_reg == '0)
        else $error("delay state not cleared after the last sample of a block");

    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.x_load && ctrl.out_load))
        else $error("input capture and result load in the same step");

endmodule

// ===== src/biquad_filter_dc_removed.sv =====
// Top level of the DC-removing biquad section in transposed direct form II.
//
// Input samples arrive on the in_valid/in_ready channel with sample_in and
// block_end; a transfer happens when both are high. Each sample has the
// configured DC level removed and passes through one second-order section.
// One result per input leaves on the out_valid/out_ready channel as
// sample_out and out_last. A small microcode program drives one shared
// 24x32 multiplier; a sample's result is loaded into the output register at
// the last program step and out_valid rises in the next cycle. A new sample
// is taken only at the input step, after the program has finished the
// previous one. The output register lets the next sample enter while the
// previous result waits. If the receiver stalls, the program holds at its
// last step until the output register is free. Configuration registers are
// written through cfg_we, cfg_index and cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// Unknown indexes are ignored. Reset clears both delay registers and loads
// the default coefficients (unity gain, no offset). After a sample marked
// block_end both delays clear, so every block starts from zero state.
module biquad_filter_dc_removed (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [bqdc_pkg::SAMPLE_BITS-1:0]  sample_in,
    input  logic                                     block_end,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [bqdc_pkg::SAMPLE_BITS-1:0]  sample_out,
    output logic                                     out_last,
    input  logic                                     cfg_we,
    input  logic [bqdc_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [bqdc_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

    bqdc_pkg::ctrl_t ctrl;
    logic            out_free;

    bqdc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    bqdc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sample_in  (sample_in),
        .block_end  (block_end),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_ready  (out_ready),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .sample_out (sample_out),
        .out_last   (out_last)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the DC-removing biquad section biquad_filter_dc_removed.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [bqdc_pkg::SAMPLE_BITS-1:0] sample;
        logic                                    last;
    } audio_item_t;

    localparam logic signed [bqdc_pkg::SAMPLE_BITS-1:0] SMP_MAX =
        {1'b0, {(bqdc_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [bqdc_pkg::SAMPLE_BITS-1:0] SMP_MIN =
        {1'b1, {(bqdc_pkg::SAMPLE_BITS-1){1'b0}}};
    localparam logic [bqdc_pkg::CFG_DATA_BITS-1:0] COEF_MAX =
        {1'b0, {(bqdc_pkg::CFG_DATA_BITS-1){1'b1}}};
    localparam logic [bqdc_pkg::CFG_DATA_BITS-1:0] COEF_MIN =
        {1'b1, {(bqdc_pkg::CFG_DATA_BITS-1){1'b0}}};
    localparam logic [bqdc_pkg::CFG_DATA_BITS-1:0] COEF_UNITY = bqdc_pkg::GAIN_B0_RESET;
    localparam logic [bqdc_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO =
        bqdc_pkg::REG_OFFSET_LEVEL + bqdc_pkg::CFG_IDX_BITS'(1);
    localparam logic [bqdc_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = '1;
    localparam int STALL_LIMIT = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [bqdc_pkg::SAMPLE_BITS-1:0] sample_in = '0;
    logic block_end = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [bqdc_pkg::SAMPLE_BITS-1:0] sample_out;
    logic out_last;
    logic cfg_we = 1'b0;
    logic [bqdc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [bqdc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    audio_item_t sample_queue[$];
    audio_item_t filtered_queue[$];

    longint tap_coef [0:4];
    longint dc_level;
    longint delay_one;
    longint delay_two;

    bit steady = 1'b0;
    int error_count = 0;
    int stuck_cycles = 0;

    biquad_filter_dc_removed uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .block_end  (block_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .out_last   (out_last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic longint round_drop(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint to_state(input longint p);
        if (bqdc_pkg::PROD_RSH > 0)
            return round_drop(p, bqdc_pkg::PROD_RSH);
        return p <<< bqdc_pkg::PROD_LSH;
    endfunction

    function automatic audio_item_t run_filter(
        input logic signed [bqdc_pkg::SAMPLE_BITS-1:0] raw,
        input logic last
    );
        longint x;
        longint acc;
        longint y;
        longint d1;
        longint d2;
        audio_item_t res;
        x = clamp(longint'(raw) - dc_level, bqdc_pkg::SAMPLE_BITS);
        acc = to_state(tap_coef[bqdc_pkg::REG_GAIN_B0] * x) + delay_one;
        y = clamp(round_drop(acc, bqdc_pkg::OUT_SHIFT), bqdc_pkg::SAMPLE_BITS);
        d1 = to_state(tap_coef[bqdc_pkg::REG_GAIN_B1] * x)
             - to_state(tap_coef[bqdc_pkg::REG_FEEDBACK_A1] * y)
             + delay_two;
        d2 = to_state(tap_coef[bqdc_pkg::REG_GAIN_B2] * x)
             - to_state(tap_coef[bqdc_pkg::REG_FEEDBACK_A2] * y);
        delay_one = last ? 0 : clamp(d1, bqdc_pkg::STATE_BITS);
        delay_two = last ? 0 : clamp(d2, bqdc_pkg::STATE_BITS);
        res.sample = bqdc_pkg::SAMPLE_BITS'(y);
        res.last = last;
        return res;
    endfunction

    function automatic bit take_break();
        return ($urandom_range(99) < 32) && !steady;
    endfunction

    function automatic logic signed [bqdc_pkg::SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? SMP_MAX : SMP_MIN;
            1, 2: return bqdc_pkg::SAMPLE_BITS'(int'($urandom_range(4000)) - 2000);
            default: return bqdc_pkg::SAMPLE_BITS'($urandom());
        endcase
    endfunction

    task automatic write_reg(input logic [bqdc_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [bqdc_pkg::CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx <= bqdc_pkg::REG_FEEDBACK_A2)
            tap_coef[idx] = longint'($signed(data));
        else if (idx == bqdc_pkg::REG_OFFSET_LEVEL)
            dc_level = longint'($signed(data[bqdc_pkg::SAMPLE_BITS-1:0]));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_item(input logic signed [bqdc_pkg::SAMPLE_BITS-1:0] smp,
                             input logic last);
        audio_item_t item;
        item.sample = smp;
        item.last = last;
        sample_queue.push_back(item);
    endtask

    task automatic drain();
        @(negedge clk);
        while (sample_queue.size() != 0 || filtered_queue.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    task automatic random_phase(input int kind, input int count);
        int left_in_block;
        logic [bqdc_pkg::CFG_DATA_BITS-1:0] word;
        for (int r = bqdc_pkg::REG_GAIN_B0; r <= bqdc_pkg::REG_FEEDBACK_A2; r++)
        begin
            case (kind)
                0: word = int'($urandom_range(32'h7FFF_FFFF)) - (1 << 30);
                1: word = $urandom();
                default:
                begin
                    case ($urandom_range(4))
                        0: word = COEF_MAX;
                        1: word = COEF_MIN;
                        2: word = '0;
                        3: word = COEF_UNITY;
                        default: word = -COEF_UNITY;
                    endcase
                end
            endcase
            write_reg(bqdc_pkg::CFG_IDX_BITS'(r), word);
        end
        word = $urandom();
        if ($urandom_range(2) == 0)
            word = bqdc_pkg::CFG_DATA_BITS'(int'($urandom_range(2000)) - 1000);
        write_reg(bqdc_pkg::REG_OFFSET_LEVEL, word);
        write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
        left_in_block = 0;
        for (int i = 0; i < count; i++)
        begin
            if (left_in_block == 0)
                left_in_block = $urandom_range(1, 40);
            left_in_block--;
            push_item(rand_sample(), left_in_block == 0);
        end
        drain();
    endtask

    // Input side: hold the current transfer until accepted, then offer the next queued sample.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                filtered_queue.push_back(run_filter(sample_in, block_end));
                void'(sample_queue.pop_front());
            end
            if (!in_valid || in_ready)
            begin
                if (sample_queue.size() != 0 && !take_break())
                begin
                    in_valid <= 1'b1;
                    sample_in <= sample_queue[0].sample;
                    block_end <= sample_queue[0].last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        audio_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (filtered_queue.size() == 0)
                begin
                    $error("unexpected output transfer: sample_out %0d", sample_out);
                    error_count++;
                end
                else
                begin
                    want = filtered_queue.pop_front();
                    if (sample_out !== want.sample)
                    begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               want.sample, sample_out);
                        error_count++;
                    end
                    if (out_last !== want.last)
                    begin
                        $error("out_last mismatch: expected %0b, actual %0b",
                               want.last, out_last);
                        error_count++;
                    end
                end
            end
            out_ready <= !take_break();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT)
            begin
                $display("biquad_filter_dc_removed verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        tap_coef[bqdc_pkg::REG_GAIN_B0] = longint'(1) <<< bqdc_pkg::COEF_FRAC_BITS;
        tap_coef[bqdc_pkg::REG_GAIN_B1] = 0;
        tap_coef[bqdc_pkg::REG_GAIN_B2] = 0;
        tap_coef[bqdc_pkg::REG_FEEDBACK_A1] = 0;
        tap_coef[bqdc_pkg::REG_FEEDBACK_A2] = 0;
        dc_level = 0;
        delay_one = 0;
        delay_two = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset coefficients pass the sample through unchanged.
        push_item(SMP_MAX, 1'b0);
        push_item(SMP_MIN, 1'b0);
        push_item('0, 1'b0);
        push_item(bqdc_pkg::SAMPLE_BITS'(1), 1'b0);
        push_item(bqdc_pkg::SAMPLE_BITS'(-1), 1'b0);
        push_item(24'h555555, 1'b0);
        push_item(24'hAAAAAA, 1'b1);
        drain();

        // Offset subtraction overflows upward and the output saturates.
        write_reg(REG_SPARE_LO, 32'hDEAD_BEEF);
        write_reg(REG_SPARE_HI, 32'h1234_5678);
        write_reg(bqdc_pkg::REG_OFFSET_LEVEL, {8'hA5, SMP_MIN});
        write_reg(bqdc_pkg::REG_GAIN_B0, COEF_MAX);
        push_item(SMP_MAX, 1'b0);
        push_item('0, 1'b0);
        push_item(SMP_MIN, 1'b1);
        drain();

        // Offset subtraction overflows downward; feedback taps at both extremes.
        write_reg(bqdc_pkg::REG_OFFSET_LEVEL, {8'h00, SMP_MAX});
        write_reg(bqdc_pkg::REG_GAIN_B0, COEF_MIN);
        write_reg(bqdc_pkg::REG_GAIN_B1, COEF_MAX);
        write_reg(bqdc_pkg::REG_GAIN_B2, COEF_MIN);
        write_reg(bqdc_pkg::REG_FEEDBACK_A1, COEF_MAX);
        write_reg(bqdc_pkg::REG_FEEDBACK_A2, COEF_MIN);
        push_item(SMP_MIN, 1'b0);
        push_item(SMP_MIN, 1'b0);
        push_item(SMP_MAX, 1'b0);
        push_item('0, 1'b1);
        drain();

        for (int r = bqdc_pkg::REG_GAIN_B0; r <= bqdc_pkg::REG_FEEDBACK_A2; r++)
            write_reg(bqdc_pkg::CFG_IDX_BITS'(r), COEF_MIN);
        write_reg(bqdc_pkg::REG_OFFSET_LEVEL, '0);
        push_item(SMP_MAX, 1'b0);
        push_item(SMP_MIN, 1'b0);
        push_item(SMP_MAX, 1'b0);
        push_item(SMP_MIN, 1'b1);
        drain();

        for (int r = bqdc_pkg::REG_GAIN_B0; r <= bqdc_pkg::REG_FEEDBACK_A2; r++)
            write_reg(bqdc_pkg::CFG_IDX_BITS'(r), COEF_MAX);
        push_item(SMP_MAX, 1'b0);
        push_item(SMP_MIN, 1'b0);
        push_item(SMP_MAX, 1'b0);
        push_item(SMP_MIN, 1'b1);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            steady = (p == 3);
            random_phase(p % 3, 100);
        end
        steady = 1'b0;

        repeat (20) @(posedge clk);
        if (filtered_queue.size() != 0)
        begin
            $error("%0d expected results never arrived", filtered_queue.size());
            error_count++;
        end
        if (error_count == 0)
            $display("biquad_filter_dc_removed verification clean");
        else
            $display("biquad_filter_dc_removed verification failed");
        $finish;
    end

endmodule
